@@ design/ptwr_pkg.sv @@
// Shared types and constants for the page table with replacement block.
package ptwr_pkg;

    localparam int MAX_FRAMES  = 1024;
    localparam int PAGE_W      = 20;
    localparam int OFFSET_W    = 12;
    localparam int FRAME_W     = $clog2(MAX_FRAMES);
    localparam int COUNT_W     = FRAME_W + 1;
    localparam int PHYS_W      = 22;
    localparam int PAGES       = 1 << PAGE_W;
    localparam logic [31:0] SEED_DEFAULT = 32'd5635;
    localparam logic [31:0] LFSR_TAPS    = 32'h8020_0003;

    typedef enum logic [1:0] {
        CFG_FRAME_COUNT = 2'd0,
        CFG_POLICY      = 2'd1,
        CFG_RANDOM_SEED = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        POL_FIFO   = 2'd0,
        POL_CLOCK  = 2'd1,
        POL_LRU    = 2'd2,
        POL_RANDOM = 2'd3
    } t_policy;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_PT_RD,
        S_PT_CHK,
        S_FREE_RD,
        S_FREE_CHK,
        S_VIC_SEL,
        S_CLK_OWN_RD,
        S_CLK_PT_RD,
        S_CLK_CHK,
        S_LRU_RD,
        S_LRU_CHK,
        S_RND_DIV,
        S_EV_OWN_RD,
        S_EV_PT_RD,
        S_EV_WR,
        S_INSTALL,
        S_FINAL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               used;
        logic               dirty;
        logic               present;
    } t_pte;

    typedef struct packed {
        logic [31:0] virt_addr;
        logic        is_write;
    } t_req;

    typedef struct packed {
        logic [PHYS_W-1:0] phys_addr;
        logic              miss;
        logic              replaced;
        logic [PAGE_W-1:0] evicted_page;
        logic              evicted_dirty;
        logic [31:0]       miss_total;
        logic [31:0]       write_total;
        logic [31:0]       drop_total;
    } t_rsp;

endpackage

@@ design/page_table_with_replacement.sv @@
// Demand-paged address translation with FIFO, clock, LRU and random replacement.
// A hit checks the page table entry and writes it back with used set; a miss scans frames
// for a free slot and installs there. Full: FIFO takes the oldest, clock visits up to
// 2*frame_count frames, LRU scans the stamps, random a bit-serial remainder; the victim is
// evicted. One access in flight. Reset clears the 2^20 table entries; no beat is taken.
module page_table_with_replacement
    import ptwr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_req        i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsp        o_out_data
);

    t_pte                r_pt_mem    [PAGES];
    logic                r_busy_mem  [MAX_FRAMES];
    logic [PAGE_W-1:0]   r_owner_mem [MAX_FRAMES];
    logic [31:0]         r_stamp_mem [MAX_FRAMES];

    t_pte                r_pt_q;
    logic                r_busy_q;
    logic [PAGE_W-1:0]   r_owner_q;
    logic [31:0]         r_stamp_q;

    t_state              r_state, n_state;
    logic [PAGE_W-1:0]   r_clr;
    logic [COUNT_W-1:0]  r_fcount;
    t_policy             r_policy;
    logic [31:0]         r_lfsr;
    logic [31:0]         r_clock;
    logic [FRAME_W-1:0]  r_hand;
    logic [FRAME_W-1:0]  r_oldest;
    logic [31:0]         r_miss_cnt;
    logic [31:0]         r_wb_cnt;
    logic [31:0]         r_drop_cnt;

    logic [31:0]         r_va;
    logic                r_wr;
    logic [PAGE_W-1:0]   r_pg;
    logic [COUNT_W-1:0]  r_n;
    logic [FRAME_W-1:0]  r_f;
    logic [FRAME_W-1:0]  r_v;
    logic [COUNT_W:0]    r_i;
    logic [31:0]         r_best;
    logic [COUNT_W-1:0]  r_rem;
    logic [4:0]          r_bit;
    logic                r_miss;
    logic                r_repl;
    logic [PAGE_W-1:0]   r_evp;
    logic                r_evd;
    t_pte                r_e;
    logic                r_out_valid;
    t_rsp                r_out;

    logic [COUNT_W-1:0]  n_active;
    logic [PAGE_W-1:0]   pt_raddr;
    logic                pt_we;
    logic [PAGE_W-1:0]   pt_waddr;
    t_pte                pt_wdata;
    logic [COUNT_W-1:0]  f_inc;
    logic [COUNT_W-1:0]  v_inc;
    logic [FRAME_W-1:0]  v_wrap;
    logic [COUNT_W-1:0]  v_start;
    logic [FRAME_W-1:0]  v2_wrap;
    logic [COUNT_W:0]    rem_sh;
    logic [31:0]         lfsr_step;

    assign n_active = (r_fcount == '0) ? COUNT_W'(1) :
                      (r_fcount > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES) : r_fcount;
    assign f_inc    = {1'b0, r_f} + COUNT_W'(1);
    assign v_inc    = {1'b0, r_v} + COUNT_W'(1);
    assign v_wrap   = (v_inc == r_n) ? '0 : v_inc[FRAME_W-1:0];
    assign v2_wrap  = ({1'b0, v_wrap} + COUNT_W'(1) == r_n) ? '0 :
                      FRAME_W'({1'b0, v_wrap} + COUNT_W'(1));
    assign v_start  = ({1'b0, r_oldest} < r_n) ? {1'b0, r_oldest} : '0;
    assign rem_sh   = {r_rem, r_lfsr[r_bit]};
    assign lfsr_step = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : 32'd0);

    always_ff @(posedge i_clk) begin
        r_pt_q    <= r_pt_mem[pt_raddr];
        r_busy_q  <= r_busy_mem[r_f];
        r_owner_q <= r_owner_mem[r_v];
        r_stamp_q <= r_stamp_mem[r_i[FRAME_W-1:0]];
        if (pt_we) begin
            r_pt_mem[pt_waddr] <= pt_wdata;
        end
        if (r_state == S_CLEAR) begin
            r_busy_mem[r_clr[FRAME_W-1:0]] <= 1'b0;
        end else if (r_state == S_INSTALL) begin
            r_busy_mem[r_f] <= 1'b1;
        end
        if (r_state == S_INSTALL) begin
            r_owner_mem[r_f] <= r_pg;
        end
        if (r_state == S_FINAL) begin
            r_stamp_mem[r_f] <= r_clock + 32'd1;
        end
    end

    always_comb begin
        n_state  = r_state;
        pt_raddr = r_pg;
        pt_we    = 1'b0;
        pt_waddr = r_pg;
        pt_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                pt_we    = 1'b1;
                pt_waddr = r_clr;
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_PT_RD;
            end
            S_PT_RD: n_state = S_PT_CHK;
            S_PT_CHK: n_state = r_pt_q.present ? S_FINAL : S_FREE_RD;
            S_FREE_RD: n_state = S_FREE_CHK;
            S_FREE_CHK: begin
                if (!r_busy_q) n_state = S_INSTALL;
                else if (f_inc == r_n) n_state = S_VIC_SEL;
                else n_state = S_FREE_RD;
            end
            S_VIC_SEL: begin
                unique case (r_policy)
                    POL_FIFO:  n_state = S_EV_OWN_RD;
                    POL_CLOCK: n_state = S_CLK_OWN_RD;
                    POL_LRU:   n_state = S_LRU_RD;
                    default:   n_state = S_RND_DIV;
                endcase
            end
            S_CLK_OWN_RD: n_state = S_CLK_PT_RD;
            S_CLK_PT_RD: begin
                pt_raddr = r_owner_q;
                n_state  = S_CLK_CHK;
            end
            S_CLK_CHK: begin
                if (!r_pt_q.used) begin
                    n_state = S_EV_OWN_RD;
                end else begin
                    pt_we         = 1'b1;
                    pt_waddr      = r_evp;
                    pt_wdata      = r_pt_q;
                    pt_wdata.used = 1'b0;
                    n_state = (r_i + 1'b1 == {r_n, 1'b0}) ? S_EV_OWN_RD : S_CLK_OWN_RD;
                end
            end
            S_LRU_RD: n_state = S_LRU_CHK;
            S_LRU_CHK: n_state = (r_i + 1'b1 == {1'b0, r_n}) ? S_EV_OWN_RD : S_LRU_RD;
            S_RND_DIV: if (r_bit == '0) n_state = S_EV_OWN_RD;
            S_EV_OWN_RD: n_state = S_EV_PT_RD;
            S_EV_PT_RD: begin
                pt_raddr = r_owner_q;
                n_state  = S_EV_WR;
            end
            S_EV_WR: begin
                pt_we            = 1'b1;
                pt_waddr         = r_evp;
                pt_wdata         = r_pt_q;
                pt_wdata.present = 1'b0;
                n_state          = S_INSTALL;
            end
            S_INSTALL: n_state = S_FINAL;
            S_FINAL: begin
                pt_we          = 1'b1;
                pt_waddr       = r_pg;
                pt_wdata       = r_e;
                pt_wdata.used  = 1'b1;
                pt_wdata.dirty = r_e.dirty | r_wr;
                n_state        = S_DONE;
            end
            S_DONE: if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_fcount    <= COUNT_W'(MAX_FRAMES);
            r_policy    <= POL_FIFO;
            r_lfsr      <= SEED_DEFAULT;
            r_clock     <= '0;
            r_hand      <= '0;
            r_oldest    <= '0;
            r_miss_cnt  <= '0;
            r_wb_cnt    <= '0;
            r_drop_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FRAME_COUNT: r_fcount <= i_cfg_data[COUNT_W-1:0];
                    CFG_POLICY:      r_policy <= t_policy'(i_cfg_data[1:0]);
                    CFG_RANDOM_SEED: r_lfsr   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_PT_CHK: if (!r_pt_q.present) r_miss_cnt <= r_miss_cnt + 32'd1;
                S_VIC_SEL: begin
                    case (r_policy)
                        POL_FIFO: begin
                            r_oldest <= (v_start + COUNT_W'(1) == r_n) ? '0 :
                                        FRAME_W'(v_start + COUNT_W'(1));
                        end
                        POL_RANDOM: r_lfsr <= lfsr_step;
                        default: ;
                    endcase
                end
                S_CLK_CHK: begin
                    if (!r_pt_q.used) begin
                        r_hand <= v_wrap;
                    end else if (r_i + 1'b1 == {r_n, 1'b0}) begin
                        r_hand <= v2_wrap;
                    end
                end
                S_EV_WR: begin
                    if (r_pt_q.dirty) r_wb_cnt <= r_wb_cnt + 32'd1;
                    else r_drop_cnt <= r_drop_cnt + 32'd1;
                end
                S_FINAL: r_clock <= r_clock + 32'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_va   <= i_in_data.virt_addr;
                r_wr   <= i_in_data.is_write;
                r_pg   <= i_in_data.virt_addr[OFFSET_W +: PAGE_W];
                r_n    <= n_active;
                r_miss <= 1'b0;
                r_repl <= 1'b0;
                r_evp  <= '0;
                r_evd  <= 1'b0;
                r_f    <= '0;
            end
            S_PT_CHK: begin
                r_e    <= r_pt_q;
                r_f    <= r_pt_q.present ? r_pt_q.frame : '0;
                r_miss <= !r_pt_q.present;
            end
            S_FREE_CHK: if (r_busy_q && f_inc != r_n) r_f <= f_inc[FRAME_W-1:0];
            S_VIC_SEL: begin
                r_i    <= '0;
                r_best <= '1;
                r_rem  <= '0;
                r_bit  <= 5'd31;
                if (r_policy == POL_FIFO) begin
                    r_v <= v_start[FRAME_W-1:0];
                end else if (r_policy == POL_CLOCK) begin
                    r_v <= ({1'b0, r_hand} < r_n) ? r_hand : '0;
                end
            end
            S_CLK_PT_RD: r_evp <= r_owner_q;
            S_CLK_CHK: begin
                if (r_pt_q.used) begin
                    r_i <= r_i + 1'b1;
                    r_v <= v_wrap;
                end
            end
            S_LRU_CHK: begin
                if (r_stamp_q <= r_best) begin
                    r_best <= r_stamp_q;
                    r_v    <= r_i[FRAME_W-1:0];
                end
                r_i <= r_i + 1'b1;
            end
            S_RND_DIV: begin
                if (rem_sh >= {1'b0, r_n}) begin
                    r_rem <= COUNT_W'(rem_sh - {1'b0, r_n});
                    if (r_bit == '0) r_v <= FRAME_W'(rem_sh - {1'b0, r_n});
                end else begin
                    r_rem <= COUNT_W'(rem_sh);
                    if (r_bit == '0) r_v <= FRAME_W'(rem_sh);
                end
                r_bit <= r_bit - 1'b1;
            end
            S_EV_PT_RD: r_evp <= r_owner_q;
            S_EV_WR: begin
                r_repl <= 1'b1;
                r_evd  <= r_pt_q.dirty;
                r_f    <= r_v;
            end
            S_INSTALL: begin
                r_e <= t_pte'{frame: r_f, used: 1'b0, dirty: 1'b0, present: 1'b1};
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out.phys_addr     <= PHYS_W'({r_f, r_va[OFFSET_W-1:0]});
                    r_out.miss          <= r_miss;
                    r_out.replaced      <= r_repl;
                    r_out.evicted_page  <= r_evp & {PAGE_W{r_repl}};
                    r_out.evicted_dirty <= r_evd;
                    r_out.miss_total    <= r_miss_cnt;
                    r_out.write_total   <= r_wb_cnt;
                    r_out.drop_total    <= r_drop_cnt;
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_PT_RD))
        else $error("accepted beat did not start a lookup");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RND_DIV) |-> (r_rem < r_n))
        else $error("remainder out of range");

    a_miss_cnt_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_PT_CHK) |=> (r_miss_cnt == $past(r_miss_cnt)))
        else $error("miss total moved outside lookup");

endmodule
